### rtl/core/erps_pkg.sv
// Shared constants, types and helpers for the segment rotate/project block.
package erps_pkg;

  localparam int COORD_BITS   = 8;
  localparam int TRIG_BITS    = 16;
  localparam int FRAC         = TRIG_BITS - 1;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int ZOOM_FRAC    = 12;
  localparam int OFF_FRAC     = 8;
  localparam int PIX_BITS     = 8;

  // CORDIC: angles in millionths of a degree, vector in Q.30
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_BITS    = 5;
  localparam int CORDIC_GAIN  = 652032875;
  localparam int ANGLE_SCALE  = 10000;
  localparam int DEG90        = 90000000;
  localparam int DEG180       = 180000000;
  localparam int DEG360       = 360000000;
  localparam int TRIG_LIM     = (2 ** FRAC) - 1;

  // lane datapath widths
  localparam int LW       = TRIG_BITS + COORD_BITS + 3;
  localparam int MW       = LW + TRIG_BITS;
  localparam int LW2      = LW + 1;
  localparam int PROD_W   = LW2 + CFG_BITS + 1;
  localparam int SUM_W    = PROD_W + 2;
  localparam int SCR_SHIFT = FRAC + ZOOM_FRAC;
  localparam int SCR_BASE = 31;
  localparam int LANE_STAGES = 6;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ANGLE_X  = 3'd0,
    REG_ANGLE_Y  = 3'd1,
    REG_ANGLE_Z  = 3'd2,
    REG_VOFFSET  = 3'd3,
    REG_HOFFSET  = 3'd4,
    REG_ZOOM     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TRIG_LOAD,
    TRIG_ITER,
    TRIG_IDLE
  } trig_state_e;

  typedef struct packed {
    logic signed [TRIG_BITS-1:0] sx;
    logic signed [TRIG_BITS-1:0] cx;
    logic signed [TRIG_BITS-1:0] sy;
    logic signed [TRIG_BITS-1:0] cy;
    logic signed [TRIG_BITS-1:0] sz;
    logic signed [TRIG_BITS-1:0] cz;
  } trig_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pos;
    logic                clip;
  } screen_t;

  function automatic logic signed [CORDIC_W-1:0] atan_udeg(input logic [STEP_BITS-1:0] s);
    logic signed [CORDIC_W-1:0] a;
    unique case (s)
      5'd0:  a = 32'sd45000000;
      5'd1:  a = 32'sd26565051;
      5'd2:  a = 32'sd14036243;
      5'd3:  a = 32'sd7125016;
      5'd4:  a = 32'sd3576334;
      5'd5:  a = 32'sd1789911;
      5'd6:  a = 32'sd895174;
      5'd7:  a = 32'sd447614;
      5'd8:  a = 32'sd223811;
      5'd9:  a = 32'sd111906;
      5'd10: a = 32'sd55953;
      5'd11: a = 32'sd27976;
      5'd12: a = 32'sd13988;
      5'd13: a = 32'sd6994;
      5'd14: a = 32'sd3497;
      5'd15: a = 32'sd1749;
      5'd16: a = 32'sd874;
      5'd17: a = 32'sd437;
      5'd18: a = 32'sd219;
      5'd19: a = 32'sd109;
      default: a = '0;
    endcase
    return a;
  endfunction

  // truncate toward zero by 2^SCR_SHIFT, then clamp to the pixel range
  function automatic screen_t to_screen(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] q;
    screen_t r;
    q = v >>> SCR_SHIFT;
    if (v < 0) begin
      // floor of -1 with a nonzero remainder truncates to zero: no clamp
      r.pos  = '0;
      r.clip = ~&q | ~|v[SCR_SHIFT-1:0];
    end else if (q[SUM_W-1:PIX_BITS] != '0) begin
      r.pos  = '1;
      r.clip = 1'b1;
    end else begin
      r.pos  = q[PIX_BITS-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/core/erps_if.sv
// Valid/ready channel interfaces for segment requests and pixel results.
interface erps_seg_if;
  import erps_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface erps_pix_if;
  import erps_pkg::*;
  logic                valid;
  logic                ready;
  logic [PIX_BITS-1:0] start_col;
  logic [PIX_BITS-1:0] start_row;
  logic [PIX_BITS-1:0] end_col;
  logic [PIX_BITS-1:0] end_row;
  logic                clipped;
  modport source (output valid, start_col, start_row, end_col, end_row, clipped,
                  input ready);
  modport sink   (input valid, start_col, start_row, end_col, end_row, clipped,
                  output ready);
endinterface

### rtl/core/erps_trig.sv
// Shared CORDIC sequencer: sine/cosine of the three angles, one step per cycle.
module erps_trig (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           restart_i,
  input  logic [erps_pkg::CFG_BITS-1:0]  angle_x_i,
  input  logic [erps_pkg::CFG_BITS-1:0]  angle_y_i,
  input  logic [erps_pkg::CFG_BITS-1:0]  angle_z_i,
  output erps_pkg::trig_t                trig_o,
  output logic                           busy_o
);
  import erps_pkg::*;

  localparam int RS = CORDIC_FRAC - FRAC;

  trig_state_e state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic signed [CORDIC_W-1:0] ax_q, ax_d, ay_q, ay_d, th_q, th_d;
  logic neg_q, neg_d;
  logic signed [TRIG_BITS-1:0] sin_q [3];
  logic signed [TRIG_BITS-1:0] cos_q [3];
  logic wr;
  logic signed [TRIG_BITS-1:0] wsin, wcos;

  logic [CFG_BITS-1:0] ang;
  logic signed [CORDIC_W-1:0] th_raw, th_w, nx, ny, fx, fy, rx, ry, at;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    step_d  = step_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    th_d    = th_q;
    neg_d   = neg_q;
    wr      = 1'b0;
    wsin    = '0;
    wcos    = '0;

    unique case (idx_q)
      2'd0:    ang = angle_x_i;
      2'd1:    ang = angle_y_i;
      default: ang = angle_z_i;
    endcase
    th_raw = CORDIC_W'($signed(ang)) * $signed(CORDIC_W'(ANGLE_SCALE));
    th_w   = th_raw;
    if (th_raw >= DEG180) begin
      th_w = th_raw - DEG360;
    end else if (th_raw < -DEG180) begin
      th_w = th_raw + DEG360;
    end

    at = atan_udeg(step_q);
    if (th_q >= 0) begin
      nx = ax_q - (ay_q >>> step_q);
      ny = ay_q + (ax_q >>> step_q);
    end else begin
      nx = ax_q + (ay_q >>> step_q);
      ny = ay_q - (ax_q >>> step_q);
    end
    fx = neg_q ? -nx : nx;
    fy = neg_q ? -ny : ny;
    rx = (fx + (CORDIC_W'(1) <<< (RS - 1))) >>> RS;
    ry = (fy + (CORDIC_W'(1) <<< (RS - 1))) >>> RS;

    unique case (state_q)
      TRIG_LOAD: begin
        neg_d = 1'b0;
        th_d  = th_w;
        if (th_w > DEG90) begin
          th_d  = th_w - DEG180;
          neg_d = 1'b1;
        end else if (th_w < -DEG90) begin
          th_d  = th_w + DEG180;
          neg_d = 1'b1;
        end
        ax_d    = CORDIC_W'(CORDIC_GAIN);
        ay_d    = '0;
        step_d  = '0;
        state_d = TRIG_ITER;
      end
      TRIG_ITER: begin
        ax_d   = nx;
        ay_d   = ny;
        th_d   = (th_q >= 0) ? th_q - at : th_q + at;
        step_d = step_q + 1'b1;
        if (step_q == STEP_BITS'(CORDIC_STEPS - 1)) begin
          wr = 1'b1;
          if (rx > TRIG_LIM)       wcos = TRIG_BITS'(TRIG_LIM);
          else if (rx < -TRIG_LIM) wcos = TRIG_BITS'(-TRIG_LIM);
          else                     wcos = rx[TRIG_BITS-1:0];
          if (ry > TRIG_LIM)       wsin = TRIG_BITS'(TRIG_LIM);
          else if (ry < -TRIG_LIM) wsin = TRIG_BITS'(-TRIG_LIM);
          else                     wsin = ry[TRIG_BITS-1:0];
          if (idx_q == 2'd2) begin
            state_d = TRIG_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = TRIG_LOAD;
          end
        end
      end
      default: begin
      end
    endcase

    if (restart_i) begin
      state_d = TRIG_LOAD;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_LOAD;
      idx_q   <= '0;
      step_q  <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;
    ay_q <= ay_d;
    th_q <= th_d;
    if (wr) begin
      sin_q[idx_q] <= wsin;
      cos_q[idx_q] <= wcos;
    end
  end

  assign trig_o.sx = sin_q[0];
  assign trig_o.cx = cos_q[0];
  assign trig_o.sy = sin_q[1];
  assign trig_o.cy = cos_q[1];
  assign trig_o.sz = sin_q[2];
  assign trig_o.cz = cos_q[2];
  assign busy_o    = (state_q != TRIG_IDLE);

endmodule

### rtl/core/erps_lane.sv
// One endpoint lane: X/Y/Z rotation, offset and zoom, six register stages.
module erps_lane (
  input  logic                                 clk_i,
  input  logic                                 adv_i,
  input  logic signed [erps_pkg::COORD_BITS-1:0] x_i,
  input  logic signed [erps_pkg::COORD_BITS-1:0] y_i,
  input  logic signed [erps_pkg::COORD_BITS-1:0] z_i,
  input  erps_pkg::trig_t                      trig_i,
  input  logic [erps_pkg::CFG_BITS-1:0]        voff_i,
  input  logic [erps_pkg::CFG_BITS-1:0]        hoff_i,
  input  logic [erps_pkg::CFG_BITS-1:0]        zoom_i,
  output logic signed [erps_pkg::PROD_W-1:0]   cprod_o,
  output logic signed [erps_pkg::PROD_W-1:0]   rprod_o
);
  import erps_pkg::*;

  function automatic logic signed [LW-1:0] rnd(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] t;
    t = (v + (MW'(1) <<< (FRAC - 1))) >>> FRAC;
    return t[LW-1:0];
  endfunction

  logic signed [LW-1:0]     cx, sx, cy, sy, cz, sz;
  logic signed [LW-1:0]     s1_y1_q, s1_z1_q, s1_x_q;
  logic signed [MW-1:0]     s2_m1_q, s2_m2_q, s2_m3_q, s2_m4_q;
  logic signed [LW-1:0]     s2_y1_q;
  logic signed [LW-1:0]     s3_x2_q, s3_z2_q, s3_y1_q;
  logic signed [MW-1:0]     s4_p1_q, s4_p2_q;
  logic signed [LW-1:0]     s4_z2_q;
  logic signed [LW2-1:0]    s5_zu_q, s5_yr_q;
  logic signed [PROD_W-1:0] s6_cp_q, s6_rp_q;
  logic signed [PROD_W-1:0] zoom_s;

  assign cx = LW'(trig_i.cx);
  assign sx = LW'(trig_i.sx);
  assign cy = LW'(trig_i.cy);
  assign sy = LW'(trig_i.sy);
  assign cz = LW'(trig_i.cz);
  assign sz = LW'(trig_i.sz);
  assign zoom_s = $signed(PROD_W'(zoom_i));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // rotation about x
      s1_y1_q <= cx * LW'(y_i) + sx * LW'(z_i);
      s1_z1_q <= cx * LW'(z_i) - sx * LW'(y_i);
      s1_x_q  <= LW'(x_i);
      // rotation about y, products
      s2_m1_q <= MW'(cy) * MW'(s1_z1_q);
      s2_m2_q <= MW'(sy) * MW'(s1_z1_q);
      s2_m3_q <= MW'(cy) * MW'(s1_x_q);
      s2_m4_q <= MW'(sy) * MW'(s1_x_q);
      s2_y1_q <= s1_y1_q;
      // x term is an exact multiple of one, so it passes the rounding unchanged
      s3_x2_q <= s2_m3_q[LW-1:0] + rnd(s2_m2_q);
      s3_z2_q <= rnd(s2_m1_q) - s2_m4_q[LW-1:0];
      s3_y1_q <= s2_y1_q;
      // rotation about z, products
      s4_p1_q <= MW'(sz) * MW'(s3_x2_q);
      s4_p2_q <= MW'(cz) * MW'(s3_y1_q);
      s4_z2_q <= s3_z2_q;
      // offsets moved from Q8.8 to Q.F
      s5_yr_q <= LW2'(rnd(s4_p1_q + s4_p2_q))
                 + (LW2'($signed(hoff_i)) <<< (FRAC - OFF_FRAC));
      s5_zu_q <= LW2'(s4_z2_q) + (LW2'($signed(voff_i)) <<< (FRAC - OFF_FRAC));
      // zoom
      s6_cp_q <= PROD_W'(s5_zu_q) * zoom_s;
      s6_rp_q <= PROD_W'(s5_yr_q) * zoom_s;
    end
  end

  assign cprod_o = s6_cp_q;
  assign rprod_o = s6_rp_q;

endmodule

### rtl/core/euler_rotate_project_segment_top.sv
// Top level: config registers, trig sequencer, two endpoint lanes and merge stage.
// A request passes the 6 lane stages and then the merge register to result valid.
// Throughput: one segment request per cycle while the trig table is settled and
// no stall holds the result register. After reset and any angle write, the shared
// CORDIC unit rebuilds sine/cosine of the 3 angles; no request is accepted then.
// Reset (rst_ni, async, active low) sets all angles/offsets to 0 and zoom to 1.0.
module euler_rotate_project_segment_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [erps_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [erps_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  erps_seg_if.sink                          seg_i,
  erps_pix_if.source                        pix_o
);
  import erps_pkg::*;

  // configuration registers
  logic [CFG_BITS-1:0] ang_x_q, ang_y_q, ang_z_q, voff_q, hoff_q, zoom_q;
  logic                restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
      voff_q  <= '0;
      hoff_q  <= '0;
      zoom_q  <= CFG_BITS'(1 << ZOOM_FRAC);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ANGLE_X: ang_x_q <= cfg_wdata_i;
        REG_ANGLE_Y: ang_y_q <= cfg_wdata_i;
        REG_ANGLE_Z: ang_z_q <= cfg_wdata_i;
        REG_VOFFSET: voff_q  <= cfg_wdata_i;
        REG_HOFFSET: hoff_q  <= cfg_wdata_i;
        REG_ZOOM:    zoom_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // any angle change invalidates the trig values
  assign restart = cfg_we_i && (cfg_idx_i == REG_ANGLE_X || cfg_idx_i == REG_ANGLE_Y
                                || cfg_idx_i == REG_ANGLE_Z);

  trig_t trig;
  logic  busy;

  erps_trig u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .angle_x_i (ang_x_q),
    .angle_y_i (ang_y_q),
    .angle_z_i (ang_z_q),
    .trig_o    (trig),
    .busy_o    (busy)
  );

  // whole pipeline moves together; it stalls only when a valid result is not taken
  logic                   adv, fire;
  logic [LANE_STAGES-1:0] vld_q;

  assign adv         = !pix_o.valid || pix_o.ready;
  assign seg_i.ready = adv && !busy;
  assign fire        = seg_i.valid && seg_i.ready;

  logic signed [PROD_W-1:0] s_cp, s_rp, e_cp, e_rp;

  erps_lane u_lane_start (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .x_i     (seg_i.start_x),
    .y_i     (seg_i.start_y),
    .z_i     (seg_i.start_z),
    .trig_i  (trig),
    .voff_i  (voff_q),
    .hoff_i  (hoff_q),
    .zoom_i  (zoom_q),
    .cprod_o (s_cp),
    .rprod_o (s_rp)
  );

  erps_lane u_lane_end (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .x_i     (seg_i.end_x),
    .y_i     (seg_i.end_y),
    .z_i     (seg_i.end_z),
    .trig_i  (trig),
    .voff_i  (voff_q),
    .hoff_i  (hoff_q),
    .zoom_i  (zoom_q),
    .cprod_o (e_cp),
    .rprod_o (e_rp)
  );

  // merge: add screen origin, truncate, clamp, combine clip flags
  localparam logic signed [SUM_W-1:0] BASE = SUM_W'(SCR_BASE) <<< SCR_SHIFT;

  screen_t sc, sr, ec, er;
  assign sc = to_screen(BASE - SUM_W'(s_cp));
  assign sr = to_screen(SUM_W'(s_rp) + BASE);
  assign ec = to_screen(BASE - SUM_W'(e_cp));
  assign er = to_screen(SUM_W'(e_rp) + BASE);

  logic                out_vld_q;
  logic [PIX_BITS-1:0] s_col_q, s_row_q, e_col_q, e_row_q;
  logic                clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[LANE_STAGES-2:0], fire};
      out_vld_q <= vld_q[LANE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_col_q <= sc.pos;
      s_row_q <= sr.pos;
      e_col_q <= ec.pos;
      e_row_q <= er.pos;
      clip_q  <= sc.clip | sr.clip | ec.clip | er.clip;
    end
  end

  assign pix_o.valid     = out_vld_q;
  assign pix_o.start_col = s_col_q;
  assign pix_o.start_row = s_row_q;
  assign pix_o.end_col   = e_col_q;
  assign pix_o.end_row   = e_row_q;
  assign pix_o.clipped   = clip_q;

  // no request taken while the trig values are being rebuilt
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !seg_i.ready) else $error("request accepted during trig rebuild");

  // a stall freezes every in-flight request
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q)) else $error("pipeline moved while stalled");

  // clip flag only when some coordinate sits at a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.start_col != '0 && pix_o.start_col != '1
     && pix_o.start_row != '0 && pix_o.start_row != '1
     && pix_o.end_col != '0 && pix_o.end_col != '1
     && pix_o.end_row != '0 && pix_o.end_row != '1) |-> !pix_o.clipped)
    else $error("clip set with no clamped coordinate");

endmodule
